FILE: rtl/core/lce_pkg.sv
// Shared constants, types and helpers of the line envelope tree.
package lce_pkg;

   localparam int POOL_NODES_DEF = 4096;
   localparam int X_BITS_DEF     = 32;
   localparam int SLOPE_W        = 32;
   localparam int ICPT_W         = 63;
   localparam int VALUE_W        = 64;
   localparam int DATA_W         = 32;
   localparam int CSR_ADDR_W     = 4;
   localparam int XHI_RESET      = 1048575;

   localparam logic [1:0] REG_X_LOW    = 2'd0;
   localparam logic [1:0] REG_X_HIGH   = 2'd1;
   localparam logic [1:0] REG_MODE_MIN = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_IMUL,
      ST_DECIDE,
      ST_ALLOC0,
      ST_ALLOC1,
      ST_QMUL,
      ST_QSTEP,
      ST_DESCEND,
      ST_DONE
   } state_type;

   function automatic logic better(input logic signed [VALUE_W-1:0] a,
                                   input logic signed [VALUE_W-1:0] b,
                                   input logic                      mode_min);
      better = mode_min ? (a < b) : (a > b);
   endfunction

endpackage

FILE: rtl/core/lce_req_if.sv
// Request channel carrying insert and query words.
interface lce_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic signed [lce_pkg::SLOPE_W-1:0]   slope;
   logic signed [lce_pkg::ICPT_W-1:0]    intercept;
   logic signed [31:0]                   x;

   modport source (output valid, op, slope, intercept, x, input ready);
   modport sink   (input valid, op, slope, intercept, x, output ready);
endinterface

FILE: rtl/core/lce_rsp_if.sv
// Response channel carrying one result word per request.
interface lce_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lce_pkg::VALUE_W-1:0]   value;
   logic                                 found;
   logic                                 pool_full;

   modport source (output valid, value, found, pool_full, input ready);
   modport sink   (input valid, value, found, pool_full, output ready);
endinterface

FILE: rtl/core/lce_csr.sv
// Configuration registers behind the APB-style port.
module lce_csr #(
   parameter int X_BITS = lce_pkg::X_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lce_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lce_pkg::DATA_W-1:0]        pwdata,
   output logic [lce_pkg::DATA_W-1:0]        prdata,
   output logic signed [X_BITS-1:0]          x_low,
   output logic signed [X_BITS-1:0]          x_high,
   output logic                              mode_min
);
   import lce_pkg::*;

   logic signed [X_BITS-1:0] xlo_ff, xhi_ff;
   logic                     mode_ff;
   logic                     wr_en;
   logic signed [DATA_W-1:0] xlo_ext, xhi_ext;

   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         xlo_ff  <= '0;
         xhi_ff  <= X_BITS'(XHI_RESET);
         mode_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_X_LOW:    xlo_ff  <= pwdata[X_BITS-1:0];
            REG_X_HIGH:   xhi_ff  <= pwdata[X_BITS-1:0];
            REG_MODE_MIN: mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   assign xlo_ext = xlo_ff;
   assign xhi_ext = xhi_ff;

   always_comb begin
      unique case (paddr[3:2])
         REG_X_LOW:    prdata = xlo_ext;
         REG_X_HIGH:   prdata = xhi_ext;
         REG_MODE_MIN: prdata = {{(DATA_W-1){1'b0}}, mode_ff};
         default:      prdata = '0;
      endcase
   end

   assign x_low    = xlo_ff;
   assign x_high   = xhi_ff;
   assign mode_min = mode_ff;
endmodule

FILE: rtl/core/lce_mac.sv
// Shared two-stage multiply-add unit evaluating slope * x + intercept.
module lce_mac #(
   parameter int X_BITS = lce_pkg::X_BITS_DEF
) (
   input  logic                                  clock,
   input  logic signed [lce_pkg::SLOPE_W-1:0]    slope,
   input  logic signed [X_BITS-1:0]              point,
   input  logic signed [lce_pkg::ICPT_W-1:0]     intercept,
   output logic signed [lce_pkg::VALUE_W-1:0]    sum
);
   import lce_pkg::*;

   logic signed [SLOPE_W+X_BITS-1:0] prod_ff;
   logic signed [ICPT_W-1:0]         c_ff;
   logic signed [VALUE_W-1:0]        sum_ff;
   logic signed [VALUE_W-1:0]        prod_ext, c_ext;

   assign prod_ext = prod_ff;
   assign c_ext    = c_ff;

   always_ff @(posedge clock) begin
      prod_ff <= slope * point;
      c_ff    <= intercept;
      sum_ff  <= prod_ext + c_ext;
   end

   assign sum = sum_ff;
endmodule

FILE: rtl/core/lce_ram.sv
// Single-port-write, registered-read node store.
module lce_ram #(
   parameter int DEPTH = lce_pkg::POOL_NODES_DEF,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/line_envelope_tree.sv
// Line envelope tree: top level with the tree walk sequencer.
// Keeps the upper or lower envelope of lines y = slope*x + intercept over
// x_low..x_high in a segment tree built from a node pool.
// req_chan: op 0 inserts (slope, intercept), op 1 queries at x.
// rsp_chan: one word per request: value, found, pool_full.
// APB port: x_low at 0x0, x_high at 0x4, mode_min at 0x8; write only while idle.
// One request walks one tree level at a time through the node memory
// (one read and one write port) and one shared multiply-add unit.
// A query level evaluates the node's line at x when it holds one; an insert
// level makes six line evaluations through the shared unit and takes a child
// pair from the pool when needed. A walk covers up to X_BITS + 1 levels.
// One request at a time; req_chan.ready is low while a request is walked.
// A finished word waits in the output register; the next request is taken
// meanwhile, and the walk holds only when a second word is ready to leave.
// Reset: synchronous; empties the tree (root flags in flip-flops, other nodes
// are cleared as they are taken from the pool) and reloads the registers.
module line_envelope_tree #(
   parameter int POOL_NODES = lce_pkg::POOL_NODES_DEF,
   parameter int X_BITS     = lce_pkg::X_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lce_req_if.sink                           req_chan,
   lce_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lce_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lce_pkg::DATA_W-1:0]        pwdata,
   output logic [lce_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);
   import lce_pkg::*;

   localparam int IW = $clog2(POOL_NODES);
   localparam int WW = 2 + IW + SLOPE_W + ICPT_W;
   localparam logic [IW:0] NU_LIMIT = (IW+1)'(POOL_NODES - 2);

   logic signed [X_BITS-1:0] cfg_xlo, cfg_xhi;
   logic                     cfg_mode;

   state_type state_ff, state_in;

   logic                       op_ff;
   logic signed [SLOPE_W-1:0]  cur_s_ff, cur_s_in;
   logic signed [ICPT_W-1:0]   cur_c_ff, cur_c_in;
   logic signed [X_BITS-1:0]   x_ff, x_in;
   logic signed [X_BITS-1:0]   lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [IW-1:0]              node_ff, node_in, base_ff, base_in;
   logic                       left_ff, left_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic signed [VALUE_W-1:0]  newv_ff, newv_in, best_ff, best_in;
   logic                       wl_ff, wl_in, wm_ff, wm_in, wr_ff, wr_in;
   logic                       found_ff, found_in, full_ff, full_in;
   logic [IW:0]                nused_ff, nused_in;
   logic                       root_line_ff, root_ch_ff;
   logic                       rsp_valid_ff;
   logic signed [VALUE_W-1:0]  rsp_value_ff;
   logic                       rsp_found_ff, rsp_full_ff;

   logic                       accept, out_free;
   logic                       ram_we, ram_re;
   logic [IW-1:0]              ram_waddr;
   logic [WW-1:0]              ram_wdata, ram_rdata;

   logic                       rd_line, rd_ch;
   logic [IW-1:0]              rd_base;
   logic signed [SLOPE_W-1:0]  rd_s;
   logic signed [ICPT_W-1:0]   rd_c;

   logic signed [SLOPE_W-1:0]  mac_s;
   logic signed [X_BITS-1:0]   mac_x;
   logic signed [ICPT_W-1:0]   mac_c;
   logic signed [VALUE_W-1:0]  mac_sum;

   logic signed [X_BITS:0]     span;
   logic                       dc_none, dc_both, dc_leaf, dc_pool_out, dc_alloc;
   logic                       dc_store, dc_left;

   lce_csr #(.X_BITS(X_BITS)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .x_low    (cfg_xlo),
      .x_high   (cfg_xhi),
      .mode_min (cfg_mode)
   );

   lce_mac #(.X_BITS(X_BITS)) u_mac (
      .clock     (clock),
      .slope     (mac_s),
      .point     (mac_x),
      .intercept (mac_c),
      .sum       (mac_sum)
   );

   lce_ram #(.DEPTH(POOL_NODES), .WIDTH(WW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (node_ff),
      .rdata (ram_rdata)
   );

   assign pready   = 1'b1;
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value     = rsp_value_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.pool_full = rsp_full_ff;

   // node word: {has_line, has_children, child_base, slope, intercept}
   assign rd_line = (node_ff == '0) ? root_line_ff : ram_rdata[WW-1];
   assign rd_ch   = (node_ff == '0) ? root_ch_ff   : ram_rdata[WW-2];
   assign rd_base = ram_rdata[WW-3 -: IW];
   assign rd_s    = ram_rdata[SLOPE_W+ICPT_W-1 -: SLOPE_W];
   assign rd_c    = ram_rdata[ICPT_W-1:0];

   assign span = {hi_ff[X_BITS-1], hi_ff} - {lo_ff[X_BITS-1], lo_ff};

   always_comb begin
      if (op_ff == OP_QUERY) begin
         mac_s = rd_s;
         mac_c = rd_c;
         mac_x = x_ff;
      end else begin
         mac_s = cnt_ff[0] ? rd_s : cur_s_ff;
         mac_c = cnt_ff[0] ? rd_c : cur_c_ff;
         unique case (cnt_ff[2:1])
            2'd0:    mac_x = lo_ff;
            2'd1:    mac_x = mid_ff;
            default: mac_x = hi_ff;
         endcase
      end
   end

   assign dc_none     = !wl_ff && !wr_ff;
   assign dc_both     = wl_ff && wr_ff;
   assign dc_store    = dc_both || wm_ff;
   assign dc_left     = wm_ff ? !wl_ff : wl_ff;
   assign dc_leaf     = (lo_ff == hi_ff);
   assign dc_pool_out = (nused_ff > NU_LIMIT);
   assign dc_alloc    = !dc_none && !dc_both && !dc_leaf && !rd_ch && !dc_pool_out;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (cfg_xlo > cfg_xhi) ? ST_DONE : ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (op_ff == OP_QUERY) begin
               state_in = rd_line ? ST_QMUL : ST_QSTEP;
            end else begin
               state_in = rd_line ? ST_IMUL : ST_DONE;
            end
         end
         ST_IMUL: begin
            if (cnt_ff == 3'd7) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (dc_none || dc_both || dc_leaf) begin
               state_in = ST_DONE;
            end else if (rd_ch) begin
               state_in = ST_DESCEND;
            end else if (dc_pool_out) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ALLOC0;
            end
         end
         ST_ALLOC0: state_in = ST_ALLOC1;
         ST_ALLOC1: state_in = ST_DESCEND;
         ST_QMUL: begin
            if (cnt_ff == 3'd2) begin
               state_in = ST_QSTEP;
            end
         end
         ST_QSTEP: state_in = (!rd_ch || lo_ff >= hi_ff) ? ST_DONE : ST_DESCEND;
         ST_DESCEND: state_in = ST_READ;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      ram_re    = (state_ff == ST_READ);
      ram_we    = 1'b0;
      ram_waddr = node_ff;
      ram_wdata = {1'b1, rd_ch, rd_base, cur_s_ff, cur_c_ff};
      unique case (state_ff)
         ST_EVAL: begin
            ram_we = (op_ff == OP_INSERT) && !rd_line;
         end
         ST_DECIDE: begin
            ram_we    = !dc_none && (dc_store || dc_alloc);
            ram_wdata = {1'b1, rd_ch || dc_alloc,
                         dc_alloc ? nused_ff[IW-1:0] : rd_base,
                         dc_store ? cur_s_ff : rd_s,
                         dc_store ? cur_c_ff : rd_c};
         end
         ST_ALLOC0: begin
            ram_we    = 1'b1;
            ram_waddr = base_ff;
            ram_wdata = '0;
         end
         ST_ALLOC1: begin
            ram_we    = 1'b1;
            ram_waddr = IW'(base_ff + 1'b1);
            ram_wdata = '0;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cur_s_in = cur_s_ff;
      cur_c_in = cur_c_ff;
      x_in     = x_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      node_in  = node_ff;
      base_in  = base_ff;
      left_in  = left_ff;
      cnt_in   = cnt_ff + 3'd1;
      newv_in  = newv_ff;
      best_in  = best_ff;
      wl_in    = wl_ff;
      wm_in    = wm_ff;
      wr_in    = wr_ff;
      found_in = found_ff;
      full_in  = full_ff;
      nused_in = nused_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cur_s_in = req_chan.slope;
            cur_c_in = req_chan.intercept;
            x_in     = req_chan.x[X_BITS-1:0];
            lo_in    = cfg_xlo;
            hi_in    = cfg_xhi;
            node_in  = '0;
            best_in  = '0;
            found_in = 1'b0;
            full_in  = 1'b0;
         end
         ST_READ: begin
            mid_in = lo_ff + $signed(span[X_BITS:1]);
         end
         ST_EVAL: begin
            cnt_in = '0;
         end
         ST_IMUL: begin
            unique case (cnt_ff)
               3'd2, 3'd4, 3'd6: newv_in = mac_sum;
               3'd3: wl_in = better(newv_ff, mac_sum, cfg_mode);
               3'd5: wm_in = better(newv_ff, mac_sum, cfg_mode);
               3'd7: wr_in = better(newv_ff, mac_sum, cfg_mode);
               default: ;
            endcase
         end
         ST_DECIDE: begin
            left_in = dc_left;
            base_in = rd_ch ? rd_base : nused_ff[IW-1:0];
            if (wm_ff && !dc_both && !dc_none) begin
               cur_s_in = rd_s;
               cur_c_in = rd_c;
            end
            full_in = !dc_none && !dc_both && !dc_leaf && !rd_ch && dc_pool_out;
         end
         ST_ALLOC1: begin
            nused_in = nused_ff + (IW+1)'(2);
         end
         ST_QMUL: begin
            if (cnt_ff == 3'd2) begin
               if (!found_ff || better(mac_sum, best_ff, cfg_mode)) begin
                  best_in = mac_sum;
               end
               found_in = 1'b1;
            end
         end
         ST_QSTEP: begin
            base_in = rd_base;
            left_in = (x_ff <= mid_ff);
         end
         ST_DESCEND: begin
            if (left_ff) begin
               node_in = base_ff;
               hi_in   = mid_ff;
            end else begin
               node_in = IW'(base_ff + 1'b1);
               lo_in   = mid_ff + X_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nused_ff     <= (IW+1)'(1);
         root_line_ff <= 1'b0;
         root_ch_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nused_ff <= nused_in;
         if (ram_we && ram_waddr == '0) begin
            root_line_ff <= ram_wdata[WW-1];
            root_ch_ff   <= ram_wdata[WW-2];
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         op_ff <= req_chan.op;
      end
      cur_s_ff <= cur_s_in;
      cur_c_ff <= cur_c_in;
      x_ff     <= x_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      node_ff  <= node_in;
      base_ff  <= base_in;
      left_ff  <= left_in;
      cnt_ff   <= cnt_in;
      newv_ff  <= newv_in;
      best_ff  <= best_in;
      wl_ff    <= wl_in;
      wm_ff    <= wm_in;
      wr_ff    <= wr_in;
      found_ff <= found_in;
      full_ff  <= full_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_value_ff <= best_ff;
         rsp_found_ff <= found_ff;
         rsp_full_ff  <= full_ff;
      end
   end

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nused_ff <= (IW+1)'(POOL_NODES))
      else $error("node pool count beyond pool size");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("second word taken while a walk is running");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.found && rsp_chan.pool_full))
      else $error("result flags both query and insert outcome");
endmodule

FILE: sim/line_envelope_tree_tb.sv
// Testbench for the line envelope tree: directed and random insert/query words checked against a behavioral tree.
`timescale 1ns / 1ps
module line_envelope_tree_tb;
   import lce_pkg::*;

   localparam int NPOOL = POOL_NODES_DEF;
   localparam longint LIMIT = 64'd6000000;

   typedef struct packed {
      logic                     op;
      logic signed [31:0]       slope;
      logic signed [62:0]       intercept;
      logic signed [31:0]       x;
   } req_word_t;

   typedef struct packed {
      logic signed [63:0] value;
      logic               found;
      logic               pool_full;
   } rsp_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   lce_req_if req_chan ();
   lce_rsp_if rsp_chan ();

   line_envelope_tree uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // tree copy
   longint tr_lo, tr_hi;
   bit     tr_min;
   logic signed [31:0] t_slope [NPOOL];
   logic signed [62:0] t_icpt [NPOOL];
   bit     t_line [NPOOL];
   bit     t_kids [NPOOL];
   int     t_base [NPOOL];
   int     t_used;

   req_word_t pending_words[$];
   rsp_word_t expected_words[$];
   int  errors = 0;
   longint cycles = 0;
   bit  stall_go = 1'b0;
   bit  stall_rx = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit wins(longint a, longint b);
      return tr_min ? (a < b) : (a > b);
   endfunction

   function automatic longint mid_of(longint lo, longint hi);
      return lo + ((hi - lo) >>> 1);
   endfunction

   function automatic bit tree_insert(longint s_in, longint c_in);
      int node;
      longint lo, hi, md, s, c, os, oc, tmp;
      bit wl, wm, wr;
      node = 0; lo = tr_lo; hi = tr_hi; s = s_in; c = c_in;
      if (lo > hi) return 1'b0;
      forever begin
         if (!t_line[node]) begin
            t_slope[node] = 32'(s); t_icpt[node] = 63'(c); t_line[node] = 1'b1;
            return 1'b0;
         end
         md = mid_of(lo, hi);
         os = t_slope[node]; oc = t_icpt[node];
         wl = wins(s * lo + c, os * lo + oc);
         wm = wins(s * md + c, os * md + oc);
         wr = wins(s * hi + c, os * hi + oc);
         if (!wl && !wr) return 1'b0;
         if (wl && wr) begin
            t_slope[node] = 32'(s); t_icpt[node] = 63'(c);
            return 1'b0;
         end
         if (wm) begin
            t_slope[node] = 32'(s); t_icpt[node] = 63'(c);
            tmp = s; s = os; os = tmp;
            tmp = c; c = oc; oc = tmp;
            wl = !wl;
         end
         if (lo == hi) return 1'b0;
         if (!t_kids[node]) begin
            if (t_used > NPOOL - 2) return 1'b1;
            t_base[node] = t_used; t_kids[node] = 1'b1;
            t_line[t_used] = 1'b0; t_kids[t_used] = 1'b0;
            t_line[t_used+1] = 1'b0; t_kids[t_used+1] = 1'b0;
            t_used += 2;
         end
         if (wl) begin
            node = t_base[node]; hi = md;
         end else begin
            node = t_base[node] + 1; lo = md + 1;
         end
         if (node >= NPOOL) return 1'b0;
      end
   endfunction

   function automatic rsp_word_t envelope_result(req_word_t w);
      rsp_word_t r;
      int node;
      longint lo, hi, md, v, xq;
      r = '0;
      if (w.op == OP_INSERT) begin
         r.pool_full = tree_insert(longint'(w.slope), longint'(w.intercept));
         return r;
      end
      node = 0; lo = tr_lo; hi = tr_hi; xq = longint'(w.x);
      if (lo > hi) return r;
      forever begin
         if (t_line[node]) begin
            v = longint'(t_slope[node]) * xq + longint'(t_icpt[node]);
            if (!r.found || wins(v, r.value)) r.value = v;
            r.found = 1'b1;
         end
         if (!t_kids[node] || lo >= hi) break;
         md = mid_of(lo, hi);
         if (xq <= md) begin
            node = t_base[node]; hi = md;
         end else begin
            node = t_base[node] + 1; lo = md + 1;
         end
         if (node >= NPOOL) break;
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_words.insert(expected_words.size(), envelope_result(
               {req_chan.op, req_chan.slope, req_chan.intercept, req_chan.x}));
            send_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_word_t w;
               w = pending_words.pop_front();
               req_chan.valid <= 1'b1;
               {req_chan.op, req_chan.slope, req_chan.intercept, req_chan.x} <= w;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // hold the receiver off for a long stretch
   initial begin
      wait (stall_go);
      @(posedge clock);
      stall_rx <= 1'b1;
      repeat (3000) @(posedge clock);
      stall_rx <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word value=%0d", rsp_chan.value);
               errors++;
            end else begin
               rsp_word_t e;
               e = expected_words.pop_front();
               if (rsp_chan.value !== e.value) begin
                  $error("value exp %0d got %0d", e.value, rsp_chan.value);
                  errors++;
               end
               if (rsp_chan.found !== e.found) begin
                  $error("found exp %0d got %0d", e.found, rsp_chan.found);
                  errors++;
               end
               if (rsp_chan.pool_full !== e.pool_full) begin
                  $error("pool_full exp %0d got %0d", e.pool_full, rsp_chan.pool_full);
                  errors++;
               end
            end
            recv_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
         end
         if (stall_rx) begin
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0; req_chan.op = 1'b0; req_chan.slope = '0;
      req_chan.intercept = '0; req_chan.x = '0;
      rsp_chan.ready = 1'b0;
   end

   task automatic csr_write(input logic [1:0] idx, input longint val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(idx) << 2; pwdata <= val[31:0];
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == REG_X_LOW) tr_lo = longint'(signed'(val[31:0]));
      else if (idx == REG_X_HIGH) tr_hi = longint'(signed'(val[31:0]));
      else tr_min = val[0];
   endtask

   task automatic queue_word(input req_word_t w);
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_chan.valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   function automatic longint rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_word_t make_word(bit full_range);
      req_word_t w;
      longint span;
      w.op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: w.slope = $urandom;
         1: w.slope = $urandom_range(0, 20) - 10;
         2: w.slope = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: w.slope = $urandom_range(0, 2000) - 1000;
      endcase
      case ($urandom_range(0, 3))
         0: w.intercept = 63'(rand64());
         1: w.intercept = 63'(longint'($urandom_range(0, 2000)) - 1000);
         2: w.intercept = $urandom_range(0, 1) ? {1'b0, {62{1'b1}}} : {1'b1, 62'd0};
         default: w.intercept = 63'(longint'($urandom_range(0, 1000000)) - 500000);
      endcase
      span = tr_hi - tr_lo;
      if (full_range || $urandom_range(0, 9) == 0) w.x = $urandom;
      else if (span >= 0)
         w.x = 32'(tr_lo + longint'({$urandom, $urandom} & 64'h7fffffffffffffff) % (span + 1));
      else w.x = $urandom;
      return w;
   endfunction

   initial begin
      req_word_t w;
      int n;
      for (int i = 0; i < NPOOL; i++) begin
         t_line[i] = 1'b0; t_kids[i] = 1'b0; t_slope[i] = '0; t_icpt[i] = '0; t_base[i] = 0;
      end
      t_used = 1; tr_lo = 0; tr_hi = XHI_RESET; tr_min = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty query, extremes, ties, out-of-range queries
      queue_word('{OP_QUERY, 0, 0, 5});
      queue_word('{OP_INSERT, 32'sh7fffffff, {1'b0, {62{1'b1}}}, 0});
      queue_word('{OP_INSERT, 32'sh80000000, {1'b1, 62'd0}, 0});
      queue_word('{OP_INSERT, 3, 7, 0});
      queue_word('{OP_INSERT, 3, 7, 0});
      queue_word('{OP_INSERT, -3, 100, 0});
      queue_word('{OP_QUERY, 0, 0, 0});
      queue_word('{OP_QUERY, 0, 0, XHI_RESET});
      queue_word('{OP_QUERY, 0, 0, 32'sh80000000});
      queue_word('{OP_QUERY, 0, 0, 32'sh7fffffff});
      queue_word('{OP_QUERY, 0, 0, -1});
      drain();

      // long receiver stall while the sender keeps offering
      for (int i = 0; i < 40; i++) queue_word(make_word(1'b0));
      stall_go = 1'b1;
      drain();

      // phases over several settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin csr_write(REG_MODE_MIN, 1); end
            1: begin csr_write(REG_X_LOW, -1000); csr_write(REG_X_HIGH, 1000); end
            2: begin csr_write(REG_X_LOW, 32'sh80000000); csr_write(REG_X_HIGH, 32'sh7fffffff);
               csr_write(REG_MODE_MIN, 0); end
            3: begin csr_write(REG_X_LOW, 5); csr_write(REG_X_HIGH, 5); end
            4: begin csr_write(REG_X_LOW, 10); csr_write(REG_X_HIGH, -10); end
            5: begin csr_write(REG_X_LOW, -7); csr_write(REG_X_HIGH, 9); csr_write(REG_MODE_MIN, 1); end
            6: begin csr_write(REG_X_LOW, 32'sh80000000); csr_write(REG_X_HIGH, -32'sd2000000000); end
            7: begin csr_write(REG_X_LOW, 0); csr_write(REG_X_HIGH, 32'sh7fffffff);
               csr_write(REG_MODE_MIN, 0); end
            8: begin csr_write(REG_X_LOW, -100000); csr_write(REG_X_HIGH, 100000); end
            default: begin csr_write(REG_X_LOW, -3); csr_write(REG_X_HIGH, 3); end
         endcase
         n = (ph == 4) ? 40 : 162;
         for (int i = 0; i < n; i++) queue_word(make_word(ph == 2));
         drain();
      end
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
